[hdl/csmo_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// csmo_pkg: shared types and constants for the min-offset counting sorter
// Default sizes, fault codes and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package csmo_pkg;

	localparam int MAX_ITEMS_DEF   = 64;
	localparam int COUNT_DEPTH_DEF = 256;
	localparam int VALUE_BITS_DEF  = 16;
	localparam int OUT_BITS        = 16;

	typedef enum logic [1:0] {
		FAULT_NONE = 2'd0,
		FAULT_DROP = 2'd1,
		FAULT_SPAN = 2'd2
	} fault_t;

	typedef struct packed {
		logic load;
		logic begin_sort;
		logic fault_out;
		logic clear_set;
		logic clr_wr;
		logic latch_slot;
		logic hist_wr;
		logic pfx_rd;
		logic place_wr;
		logic emit_rd;
	} dp_cmd_t;

	typedef struct packed {
		logic span_bad;
		logic idx_last;
		logic j_last;
		logic j_zero;
	} dp_stat_t;

	function automatic int addr_bits(input int depth);
		return (depth > 1) ? $clog2(depth) : 1;
	endfunction

endpackage
`default_nettype wire

[hdl/csmo_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// csmo_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module csmo_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [csmo_pkg::addr_bits(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic [csmo_pkg::addr_bits(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

[hdl/csmo_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// csmo_datapath: storage and arithmetic of the counting sorter
// Item, count and sorted stores, running min/max, pass counters and the
// registered result stage.
// ----------------------------------------------------------------------------
module csmo_datapath #(
	parameter int MAX_ITEMS   = csmo_pkg::MAX_ITEMS_DEF,
	parameter int COUNT_DEPTH = csmo_pkg::COUNT_DEPTH_DEF,
	parameter int VALUE_BITS  = csmo_pkg::VALUE_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire csmo_pkg::dp_cmd_t             cmd,
	output csmo_pkg::dp_stat_t                 stat,
	input  wire logic [VALUE_BITS-1:0]         sample_value,
	output logic                               strobe,
	output logic [csmo_pkg::OUT_BITS-1:0]      sorted_value,
	output logic                               end_of_set,
	output logic [1:0]                         fault_code
);

	localparam int AW = csmo_pkg::addr_bits(MAX_ITEMS);
	localparam int IW = csmo_pkg::addr_bits(COUNT_DEPTH);
	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam int VB = VALUE_BITS;
	localparam int XW = ((VB > IW) ? VB : IW) + 1;
	localparam int EW = 33;

	logic [CW-1:0]         total_q;
	logic signed [VB-1:0]  min_q;
	logic signed [VB-1:0]  max_q;
	logic                  ovf_q;
	logic [CW-1:0]         n_q;
	csmo_pkg::fault_t      code_q;
	logic [IW-1:0]         idx_q;
	logic [IW-1:0]         last_q;
	logic [CW-1:0]         sum_q;
	logic                  pv_s1;
	logic [IW-1:0]         paddr_s1;
	logic [AW-1:0]         j_q;
	logic [IW-1:0]         slot_q;
	logic [VB-1:0]         val_q;
	logic                  emit_v_s1;
	logic                  emit_last_s1;
	logic                  strobe_q;
	logic [csmo_pkg::OUT_BITS-1:0] value_q;
	logic                  last_out_q;
	csmo_pkg::fault_t      code_out_q;

	logic                  item_we;
	logic [VB-1:0]         item_rdata;
	logic                  cnt_we;
	logic [IW-1:0]         cnt_waddr;
	logic [CW-1:0]         cnt_wdata;
	logic [IW-1:0]         cnt_raddr;
	logic [CW-1:0]         cnt_rdata;
	logic                  srt_we;
	logic [AW-1:0]         srt_waddr;
	logic [VB-1:0]         srt_rdata;

	logic                  has_room;
	logic [XW-1:0]         diff;
	logic [XW-1:0]         slot_full;
	logic [IW-1:0]         slot_now;
	logic [CW-1:0]         n_m1;
	logic [CW-1:0]         sum_next;
	logic [CW-1:0]         cnt_dec;
	logic [EW-1:0]         out_ext;

	assign has_room  = (total_q < CW'(MAX_ITEMS));
	assign item_we   = cmd.load && has_room;
	assign diff      = {{(XW-VB){max_q[VB-1]}}, max_q} - {{(XW-VB){min_q[VB-1]}}, min_q};
	assign slot_full = {{(XW-VB){item_rdata[VB-1]}}, item_rdata}
	                 - {{(XW-VB){min_q[VB-1]}}, min_q};
	assign slot_now  = slot_full[IW-1:0];
	assign n_m1      = n_q - CW'(1);
	assign sum_next  = sum_q + cnt_rdata;
	assign cnt_dec   = cnt_rdata - CW'(1);
	assign out_ext   = {{(EW-VB){srt_rdata[VB-1]}}, srt_rdata};

	assign stat.span_bad = (diff >= XW'(COUNT_DEPTH));
	assign stat.idx_last = (idx_q == last_q);
	assign stat.j_last   = (j_q == n_m1[AW-1:0]);
	assign stat.j_zero   = (j_q == '0);

	always_comb begin
		cnt_we    = 1'b0;
		cnt_waddr = slot_q;
		cnt_wdata = cnt_rdata + CW'(1);
		if (cmd.clr_wr) begin
			cnt_we    = 1'b1;
			cnt_waddr = idx_q;
			cnt_wdata = '0;
		end else if (pv_s1) begin
			cnt_we    = 1'b1;
			cnt_waddr = paddr_s1;
			cnt_wdata = sum_next;
		end else if (cmd.hist_wr) begin
			cnt_we    = 1'b1;
		end else if (cmd.place_wr) begin
			cnt_we    = 1'b1;
			cnt_wdata = cnt_dec;
		end
	end

	assign cnt_raddr = cmd.pfx_rd ? idx_q : slot_now;
	assign srt_we    = cmd.place_wr;
	assign srt_waddr = cnt_dec[AW-1:0];

	csmo_ram #(.WIDTH(VB), .DEPTH(MAX_ITEMS)) u_item_ram (
		.clk   (clk),
		.we    (item_we),
		.waddr (total_q[AW-1:0]),
		.wdata (sample_value),
		.raddr (j_q),
		.rdata (item_rdata)
	);

	csmo_ram #(.WIDTH(CW), .DEPTH(COUNT_DEPTH)) u_count_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.raddr (cnt_raddr),
		.rdata (cnt_rdata)
	);

	csmo_ram #(.WIDTH(VB), .DEPTH(MAX_ITEMS)) u_sorted_ram (
		.clk   (clk),
		.we    (srt_we),
		.waddr (srt_waddr),
		.wdata (val_q),
		.raddr (j_q),
		.rdata (srt_rdata)
	);

	// running set state and pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q   <= '0;
			min_q     <= '0;
			max_q     <= '0;
			ovf_q     <= 1'b0;
			pv_s1     <= 1'b0;
			emit_v_s1 <= 1'b0;
			strobe_q  <= 1'b0;
		end else begin
			pv_s1     <= cmd.pfx_rd;
			emit_v_s1 <= cmd.emit_rd;
			strobe_q  <= cmd.fault_out || emit_v_s1;
			if (cmd.clear_set) begin
				total_q <= '0;
				min_q   <= '0;
				max_q   <= '0;
				ovf_q   <= 1'b0;
			end else if (cmd.load) begin
				if (has_room) begin
					total_q <= total_q + CW'(1);
					if (total_q == '0) begin
						min_q <= sample_value;
						max_q <= sample_value;
					end else begin
						if ($signed(sample_value) < min_q) begin
							min_q <= sample_value;
						end
						if ($signed(sample_value) > max_q) begin
							max_q <= sample_value;
						end
					end
				end else begin
					ovf_q <= 1'b1;
				end
			end
		end
	end

	// pass counters and payload
	always_ff @(posedge clk) begin
		paddr_s1     <= idx_q;
		emit_last_s1 <= stat.j_last;
		if (cmd.begin_sort) begin
			n_q    <= total_q;
			code_q <= ovf_q ? csmo_pkg::FAULT_DROP : csmo_pkg::FAULT_NONE;
			last_q <= diff[IW-1:0];
			idx_q  <= '0;
			sum_q  <= '0;
			j_q    <= '0;
		end
		if (cmd.clr_wr || cmd.pfx_rd) begin
			idx_q <= stat.idx_last ? '0 : idx_q + IW'(1);
		end
		if (pv_s1) begin
			sum_q <= sum_next;
		end
		if (cmd.latch_slot) begin
			slot_q <= slot_now;
			val_q  <= item_rdata;
		end
		if ((cmd.hist_wr || cmd.emit_rd) && !stat.j_last) begin
			j_q <= j_q + AW'(1);
		end
		if (cmd.place_wr && !stat.j_zero) begin
			j_q <= j_q - AW'(1);
		end
		if (cmd.fault_out) begin
			value_q    <= '0;
			last_out_q <= 1'b1;
			code_out_q <= csmo_pkg::FAULT_SPAN;
		end else if (emit_v_s1) begin
			value_q    <= out_ext[csmo_pkg::OUT_BITS-1:0];
			last_out_q <= emit_last_s1;
			code_out_q <= code_q;
		end
	end

	assign strobe       = strobe_q;
	assign sorted_value = value_q;
	assign end_of_set   = last_out_q;
	assign fault_code   = code_out_q;

	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= CW'(MAX_ITEMS))
		else $error("item count beyond store size");

	a_span_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (fault_code == csmo_pkg::FAULT_SPAN) |-> end_of_set)
		else $error("span fault result not marked last");

	a_emit_out: assert property (@(posedge clk) disable iff (!arst_n)
		emit_v_s1 |=> strobe)
		else $error("emitted item lost before output");

endmodule
`default_nettype wire

[hdl/csmo_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// csmo_ctrl: sequencer of the counting sorter
// Steps load, span check, clear, histogram, prefix, placement and emit passes.
// ----------------------------------------------------------------------------
module csmo_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic               final_item,
	output logic                    busy,
	output csmo_pkg::dp_cmd_t       cmd,
	input  wire csmo_pkg::dp_stat_t stat
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_CLEAR,
		S_HIST_ITEM,
		S_HIST_CNT,
		S_HIST_WR,
		S_PREFIX,
		S_PLACE_ITEM,
		S_PLACE_CNT,
		S_PLACE_WR,
		S_EMIT
	} state_t;

	state_t state_q;
	state_t state_next;

	always_comb begin
		cmd        = '0;
		state_next = state_q;
		case (state_q)
			S_IDLE: begin
				cmd.load = start;
				if (start && final_item) begin
					state_next = S_CHECK;
				end
			end
			S_CHECK: begin
				if (stat.span_bad) begin
					cmd.fault_out = 1'b1;
					cmd.clear_set = 1'b1;
					state_next    = S_IDLE;
				end else begin
					cmd.begin_sort = 1'b1;
					state_next     = S_CLEAR;
				end
			end
			S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (stat.idx_last) begin
					state_next = S_HIST_ITEM;
				end
			end
			S_HIST_ITEM: state_next = S_HIST_CNT;
			S_HIST_CNT: begin
				cmd.latch_slot = 1'b1;
				state_next     = S_HIST_WR;
			end
			S_HIST_WR: begin
				cmd.hist_wr = 1'b1;
				state_next  = stat.j_last ? S_PREFIX : S_HIST_ITEM;
			end
			S_PREFIX: begin
				cmd.pfx_rd = 1'b1;
				if (stat.idx_last) begin
					state_next = S_PLACE_ITEM;
				end
			end
			S_PLACE_ITEM: state_next = S_PLACE_CNT;
			S_PLACE_CNT: begin
				cmd.latch_slot = 1'b1;
				state_next     = S_PLACE_WR;
			end
			S_PLACE_WR: begin
				cmd.place_wr = 1'b1;
				state_next   = stat.j_zero ? S_EMIT : S_PLACE_ITEM;
			end
			S_EMIT: begin
				cmd.emit_rd = 1'b1;
				if (stat.j_last) begin
					cmd.clear_set = 1'b1;
					state_next    = S_IDLE;
				end
			end
			default: state_next = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	assign busy = (state_q != S_IDLE);

	a_final_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && final_item |=> busy)
		else $error("final request did not start the sort");

	a_emit_run: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT) && !stat.j_last |=> (state_q == S_EMIT))
		else $error("emit pass cut short");

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !busy)
		else $error("load issued while busy");

endmodule
`default_nettype wire

[hdl/counting_sort_min_offset.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// counting_sort_min_offset: stable counting sort with minimum offset
// Loads signed values, sorts the set on the final request and emits it in
// ascending order.
// ----------------------------------------------------------------------------
// Load: one request per cycle; busy stays low until the final request.
// Sort: busy after it for clear and prefix passes over the span = max - min + 1 count
//   entries, histogram and placement passes over the n stored items, and the emit pass.
// Results: n strobes back to back (one per item), each emit read registered through
//   emit_v_s1 and the result stage; a span fault gives one strobe from the check state.
// Reset: arst_n clears the set and returns to idle; stores need no clearing.
module counting_sort_min_offset #(
	parameter int MAX_ITEMS   = csmo_pkg::MAX_ITEMS_DEF,
	parameter int COUNT_DEPTH = csmo_pkg::COUNT_DEPTH_DEF,
	parameter int VALUE_BITS  = csmo_pkg::VALUE_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [VALUE_BITS-1:0]         sample_value,
	input  wire logic                          final_item,
	output logic                               strobe,
	output logic [csmo_pkg::OUT_BITS-1:0]      sorted_value,
	output logic                               end_of_set,
	output logic [1:0]                         fault_code
);

	csmo_pkg::dp_cmd_t  cmd;
	csmo_pkg::dp_stat_t stat;

	csmo_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.final_item (final_item),
		.busy       (busy),
		.cmd        (cmd),
		.stat       (stat)
	);

	csmo_datapath #(
		.MAX_ITEMS   (MAX_ITEMS),
		.COUNT_DEPTH (COUNT_DEPTH),
		.VALUE_BITS  (VALUE_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.sample_value (sample_value),
		.strobe       (strobe),
		.sorted_value (sorted_value),
		.end_of_set   (end_of_set),
		.fault_code   (fault_code)
	);

endmodule
`default_nettype wire
